[rtl/core/input_event_packet_ring_unit_defines.svh]
// Assertion macros for the input event packet ring unit.
// Defining ASSERT_OFF turns every assertion use into empty text.
`ifndef INPUT_EVENT_PACKET_RING_UNIT_DEFINES_SVH
`define INPUT_EVENT_PACKET_RING_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define IEPR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define IEPR_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define IEPR_ASSERT_ALWAYS(lbl, cond, msg)
`define IEPR_ASSERT_IMPLY(lbl, ante, cons, msg)
`endif
`endif

[rtl/core/iepr_pkg.sv]
// Shared constants, types and pointer helpers for the input event packet ring.
// No dependencies; the front end, back end, top level and testbench import this package.
package iepr_pkg;

  localparam int RING_DEPTH = 64;
  localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int MAX_RUN = 64;
  localparam int CNT_W = 7;

  localparam logic [15:0] SYNC_TYPE = 16'd0;
  localparam logic [15:0] REPORT_CODE = 16'd0;
  localparam logic [15:0] DROPPED_CODE = 16'd3;

  localparam int IN_DATA_W = 128;
  localparam int OUT_DATA_W = 120;

  // Listed from the most significant field down, so event_type sits in the lowest bits.
  typedef struct packed {
    logic [19:0]        stamp_usec;
    logic [31:0]        stamp_sec;
    logic signed [31:0] event_value;
    logic [15:0]        event_code;
    logic [15:0]        event_type;
  } event_t;

  localparam int EV_W = $bits(event_t);
  localparam int OUT_PAD_W = OUT_DATA_W - EV_W;

  typedef enum logic [1:0] {
    ST_DELIVERED = 2'd0,
    ST_PENDING   = 2'd1,
    ST_BUSY      = 2'd2,
    ST_INVALID   = 2'd3
  } status_t;

  // One classified input item as it waits between front and back.
  typedef struct packed {
    logic             is_read;
    logic             is_report;
    logic             count_zero;
    logic [CNT_W-1:0] count;
    event_t           ev;
  } cmd_t;

  typedef struct packed {
    status_t status;
    event_t  ev;
    logic    last;
  } result_t;

  typedef struct packed {
    logic running;
    logic pending;
  } back_stat_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MARK = 3'b010,
    S_RUN  = 3'b100
  } back_state_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(RING_DEPTH - 1) : p - 1'b1;
  endfunction

endpackage

[rtl/core/iepr_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module iepr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/iepr_front.sv]
// Front end: accepts input items, classifies them and holds them in a two-entry queue.
// Depends on iepr_pkg.
module iepr_front import iepr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // s_tdata fields from bit 0: event_type, event_code, event_value, stamp_sec,
  // stamp_usec, read_max; zero padding above.
  input  logic [IN_DATA_W-1:0] s_tdata,
  // s_tuser fields from bit 0: req_type.
  input  logic                 s_tuser,
  output logic                 cmd_valid,
  output cmd_t                 cmd,
  input  logic                 cmd_ready
);

  cmd_t       q [2];
  logic       head;
  logic       tail;
  logic [1:0] cnt;
  cmd_t       cls;
  logic [CNT_W-1:0] read_max;
  logic       push;
  logic       pop;

  always_comb begin
    read_max = s_tdata[EV_W +: CNT_W];
    cls.ev = event_t'(s_tdata[EV_W-1:0]);
    cls.is_read = s_tuser;
    cls.is_report = (cls.ev.event_type == SYNC_TYPE) && (cls.ev.event_code == REPORT_CODE);
    cls.count_zero = (read_max == '0);
    cls.count = (read_max > CNT_W'(MAX_RUN)) ? CNT_W'(MAX_RUN) : read_max;
  end

  assign s_tready = (cnt != 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd = q[head];
  assign push = s_tvalid && s_tready;
  assign pop = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[tail] <= cls;
    end
    if (rst) begin
      head <= 1'b0;
      tail <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        tail <= ~tail;
      end
      if (pop) begin
        head <= ~head;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[rtl/core/iepr_back.sv]
// Back end: ring pointers, event RAM, read runs and the two-entry result queue.
// Depends on iepr_pkg and iepr_ram.
module iepr_back import iepr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  cmd_t                  cmd,
  output logic                  cmd_ready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [1:0]            m_tuser,
  output logic                  m_tlast,
  output back_stat_t            stat
);

  back_state_t      state, state_next;
  logic [PTR_W-1:0] write_ptr;
  logic [PTR_W-1:0] commit_ptr;
  logic [PTR_W-1:0] read_ptr;
  logic             pending_valid;
  logic [CNT_W-1:0] pending_max;
  logic [CNT_W-1:0] run_cnt;
  logic [CNT_W-1:0] run_limit;
  event_t           mark_ev;
  logic             mark_run;
  logic             inflight;
  logic             inflight_last;

  result_t          oq [2];
  logic             oq_head;
  logic             oq_tail;
  logic [1:0]       oq_cnt;
  result_t          oq_wdata;
  result_t          oq_out;
  logic             oq_wr;

  logic             out_pop;
  logic [1:0]       occ;
  logic             room;
  logic [PTR_W-1:0] wn;
  logic             overflow;
  logic             is_push;
  logic             is_rd;
  logic             rd_run;
  logic             rd_status;
  logic             status_wr;
  status_t          st_code;
  logic             serve_pending;
  logic             run_avail;
  logic             issue;
  logic             run_last;

  logic             ram_we;
  logic [PTR_W-1:0] ram_waddr;
  event_t           ram_wdata;
  logic [EV_W-1:0]  ram_rdata;

  iepr_ram #(
    .WIDTH(EV_W),
    .DEPTH(RING_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(read_ptr),
    .rdata(ram_rdata)
  );

  always_comb begin
    out_pop = m_tvalid && m_tready;
    // Queue entries plus a RAM read still in flight must leave room for one more.
    occ = oq_cnt + {1'b0, inflight};
    room = ((occ - {1'b0, out_pop}) <= 2'd1);

    wn = ptr_next(write_ptr);
    overflow = (wn == read_ptr);
    is_push = (state == S_IDLE) && cmd_valid && !cmd.is_read;
    is_rd = (state == S_IDLE) && cmd_valid && cmd.is_read;
    serve_pending = cmd.is_report && pending_valid;
    rd_run = is_rd && !pending_valid && !cmd.count_zero && (commit_ptr != read_ptr);
    rd_status = is_rd && !rd_run;
    // A status result must not overtake the tail of a run still in the RAM pipe.
    status_wr = rd_status && room && !inflight;
    cmd_ready = is_push || rd_run || status_wr;

    if (pending_valid) begin
      st_code = ST_BUSY;
    end else if (cmd.count_zero) begin
      st_code = ST_INVALID;
    end else begin
      st_code = ST_PENDING;
    end

    run_avail = (state == S_RUN) && (read_ptr != commit_ptr) && (run_cnt != run_limit);
    issue = run_avail && room;
    run_last = (ptr_next(read_ptr) == commit_ptr) || ((run_cnt + 1'b1) == run_limit);

    oq_wr = inflight || status_wr;
    if (inflight) begin
      oq_wdata.status = ST_DELIVERED;
      oq_wdata.ev = event_t'(ram_rdata);
      oq_wdata.last = inflight_last;
    end else begin
      oq_wdata.status = st_code;
      oq_wdata.ev = '0;
      oq_wdata.last = 1'b1;
    end

    ram_we = is_push || (state == S_MARK);
    ram_waddr = (state == S_MARK) ? read_ptr : write_ptr;
    ram_wdata = (state == S_MARK) ? mark_ev : cmd.ev;

    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (is_push) begin
          if (overflow) begin
            state_next = S_MARK;
          end else if (serve_pending) begin
            state_next = S_RUN;
          end
        end else if (rd_run) begin
          state_next = S_RUN;
        end
      end
      S_MARK: begin
        state_next = mark_run ? S_RUN : S_IDLE;
      end
      S_RUN: begin
        if (!run_avail || (issue && run_last)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign oq_out = oq[oq_head];
  assign m_tvalid = (oq_cnt != 2'd0);
  assign m_tdata = {{OUT_PAD_W{1'b0}}, oq_out.ev};
  assign m_tuser = oq_out.status;
  assign m_tlast = oq_out.last;
  assign stat.running = (state == S_RUN);
  assign stat.pending = pending_valid;

  always_ff @(posedge clk) begin
    if (oq_wr) begin
      oq[oq_tail] <= oq_wdata;
    end
    if (is_push && overflow) begin
      mark_ev.event_type <= SYNC_TYPE;
      mark_ev.event_code <= DROPPED_CODE;
      mark_ev.event_value <= '0;
      mark_ev.stamp_sec <= cmd.ev.stamp_sec;
      mark_ev.stamp_usec <= cmd.ev.stamp_usec;
    end
    if (rst) begin
      state <= S_IDLE;
      write_ptr <= '0;
      commit_ptr <= '0;
      read_ptr <= '0;
      pending_valid <= 1'b0;
      pending_max <= '0;
      run_cnt <= '0;
      run_limit <= '0;
      mark_run <= 1'b0;
      inflight <= 1'b0;
      inflight_last <= 1'b0;
      oq_head <= 1'b0;
      oq_tail <= 1'b0;
      oq_cnt <= 2'd0;
    end else begin
      state <= state_next;
      inflight <= issue;
      if (issue) begin
        inflight_last <= run_last;
        read_ptr <= ptr_next(read_ptr);
        run_cnt <= run_cnt + 1'b1;
      end
      if (is_push) begin
        write_ptr <= wn;
        mark_run <= serve_pending;
        if (overflow) begin
          // The slot two behind the new write pointer becomes the dropped marker.
          read_ptr <= ptr_prev(write_ptr);
        end
        if (cmd.is_report) begin
          commit_ptr <= wn;
        end
        if (serve_pending) begin
          pending_valid <= 1'b0;
          pending_max <= '0;
          run_limit <= pending_max;
          run_cnt <= '0;
        end
      end
      if (rd_run) begin
        run_limit <= cmd.count;
        run_cnt <= '0;
      end
      if (status_wr && (st_code == ST_PENDING)) begin
        pending_valid <= 1'b1;
        pending_max <= cmd.count;
      end
      if (oq_wr) begin
        oq_tail <= ~oq_tail;
      end
      if (out_pop) begin
        oq_head <= ~oq_head;
      end
      oq_cnt <= oq_cnt + {1'b0, oq_wr} - {1'b0, out_pop};
    end
  end

endmodule

[rtl/core/input_event_packet_ring_unit.sv]
// Top level of the input event packet ring: front end, back end and assertions.
// Depends on iepr_pkg, iepr_front, iepr_back and the assertion macro header.
//
// Usage: the slave channel takes items; s_tuser low pushes one event, s_tuser
// high is a read request for up to read_max committed events (saturated to 64).
// A pushed event with the sync type and report code commits everything written.
// The master channel returns results: m_tuser is the status, m_tlast marks the
// final result of an item's run. Busy, invalid and pending reads give one
// status-only result with a zero payload.
// A push that overruns the read pointer also passes through the mark state, since
// the dropped-events marker needs a second write on the single RAM write port. A
// read run enters the run state and then streams one event per cycle while the
// result queue has room. An accepted item is registered in the input queue first.
// A status result then passes through the result queue; the first event of a run
// passes through the run state, the registered RAM read and the result queue.
// Reset clears the pointers, the pending read and both queues; the ring contents
// stay undefined and there is no clearing pass. When the receiver stalls, the
// two-entry result queue fills, the run pauses, and the input queue backs up.
`include "input_event_packet_ring_unit_defines.svh"

module input_event_packet_ring_unit import iepr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata fields from bit 0: event_type, event_code, event_value, stamp_sec,
  // stamp_usec, read_max; zero padding above.
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // s_tuser fields from bit 0: req_type.
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata fields from bit 0: out_type, out_code, out_value, out_sec, out_usec;
  // zero padding above.
  output logic [OUT_DATA_W-1:0] m_tdata,
  // m_tuser fields from bit 0: status.
  output logic [1:0]            m_tuser,
  output logic                  m_tlast
);

  logic       cmd_valid;
  logic       cmd_ready;
  cmd_t       cmd;
  back_stat_t stat;
  logic       status_only;

  iepr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_ready(cmd_ready)
  );

  iepr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_ready(cmd_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .stat     (stat)
  );

  assign status_only = m_tvalid && (m_tuser != ST_DELIVERED);

  `IEPR_ASSERT_IMPLY(a_status_last, status_only, m_tlast, "status-only result without last")
  `IEPR_ASSERT_IMPLY(a_status_zero, status_only, m_tdata == '0, "status-only result with payload")
  `IEPR_ASSERT_IMPLY(a_run_not_pending, stat.running, !stat.pending, "run while a read is pending")

endmodule

[sim/tb.sv]
// Self-checking testbench for input_event_packet_ring_unit: streams pushes and reads
// through the slave channel and checks each result against an in-bench ring predictor.
// Depends on iepr_pkg and the RTL of the block only.
module tb;
  import iepr_pkg::*;

  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PRINT_LIMIT   = 40;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;
  logic                  m_tlast;

  input_event_packet_ring_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Ring predictor state.
  event_t           ring_copy [RING_DEPTH];
  logic [PTR_W-1:0] wr_ptr = '0;
  logic [PTR_W-1:0] cm_ptr = '0;
  logic [PTR_W-1:0] rd_ptr = '0;
  logic             held_read = 1'b0;
  logic [CNT_W-1:0] held_max = '0;
  result_t          due_results [$];

  int  errors = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  overruns = 0;
  int  held_served = 0;
  int  quiet_cycles = 0;
  bit  tx_gaps = 1'b1;
  bit  rx_stalls = 1'b1;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic event_t rand_event();
    event_t ev;
    ev.event_type  = 16'($urandom);
    ev.event_code  = 16'($urandom);
    ev.event_value = $urandom;
    ev.stamp_sec   = $urandom;
    ev.stamp_usec  = 20'($urandom_range(0, 999999));
    return ev;
  endfunction

  function automatic event_t report_event();
    event_t ev;
    ev = rand_event();
    ev.event_type = SYNC_TYPE;
    ev.event_code = REPORT_CODE;
    return ev;
  endfunction

  function automatic event_t make_event(input logic [15:0] typ, input logic [15:0] cod,
                                        input logic [31:0] val, input logic [31:0] sec,
                                        input logic [19:0] usec);
    event_t ev;
    ev.event_type  = typ;
    ev.event_code  = cod;
    ev.event_value = val;
    ev.stamp_sec   = sec;
    ev.stamp_usec  = usec;
    return ev;
  endfunction

  task automatic queue_status(input status_t st);
    result_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    due_results.push_back(r);
  endtask

  // Streams committed events from the read pointer, at most limit of them.
  task automatic stream_committed(input logic [CNT_W-1:0] limit);
    int unsigned      lim;
    int unsigned      n;
    logic [PTR_W-1:0] p;
    logic [PTR_W-1:0] nxt;
    result_t          r;
    lim = (limit > MAX_RUN) ? MAX_RUN : limit;
    p = rd_ptr;
    n = 0;
    while (p != cm_ptr && n < lim) begin
      nxt = p + 1'b1;
      r.status = ST_DELIVERED;
      r.ev = ring_copy[p];
      r.last = (nxt == cm_ptr) || (n + 1 == lim);
      due_results.push_back(r);
      n++;
      p = nxt;
    end
    rd_ptr = p;
  endtask

  task automatic predict_ring(input logic is_read, input event_t ev,
                              input logic [CNT_W-1:0] cnt);
    logic [PTR_W-1:0] mark;
    event_t           marker;
    if (!is_read) begin
      ring_copy[wr_ptr] = ev;
      wr_ptr = wr_ptr + 1'b1;
      // Overrun: the slot two behind the writer becomes the dropped-events marker.
      if (wr_ptr == rd_ptr) begin
        mark = wr_ptr - PTR_W'(2);
        marker = ev;
        marker.event_type = SYNC_TYPE;
        marker.event_code = DROPPED_CODE;
        marker.event_value = '0;
        ring_copy[mark] = marker;
        rd_ptr = mark;
        overruns++;
      end
      if (ev.event_type == SYNC_TYPE && ev.event_code == REPORT_CODE) begin
        cm_ptr = wr_ptr;
        if (held_read) begin
          held_read = 1'b0;
          held_served++;
          stream_committed(held_max);
          held_max = '0;
        end
      end
    end else if (held_read) begin
      queue_status(ST_BUSY);
    end else if (cnt == '0) begin
      queue_status(ST_INVALID);
    end else if (cm_ptr == rd_ptr) begin
      held_read = 1'b1;
      held_max = cnt;
      queue_status(ST_PENDING);
    end else begin
      stream_committed(cnt);
    end
  endtask

  task automatic send_item(input logic is_read, input event_t ev, input logic [CNT_W-1:0] cnt);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= is_read;
    s_tdata  <= IN_DATA_W'({cnt, ev});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_ring(is_read, ev, cnt);
    items_sent++;
    gap = tx_gaps ? gap_len() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic push_event(input event_t ev);
    send_item(1'b0, ev, CNT_W'($urandom));
  endtask

  task automatic send_read(input logic [CNT_W-1:0] cnt);
    send_item(1'b1, rand_event(), cnt);
  endtask

  // Holds the sender off until every predicted result has been taken.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_LIMIT) $display("MISMATCH result %0d: %s", results_seen, msg);
    errors++;
  endtask

  task automatic check_result();
    result_t want;
    event_t  got;
    got = event_t'(m_tdata[EV_W-1:0]);
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result, status %0d", m_tuser));
    end else begin
      want = due_results.pop_front();
      if (m_tuser !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", m_tuser, want.status));
      if (got.event_type !== want.ev.event_type)
        report_mismatch($sformatf("type %h, want %h", got.event_type, want.ev.event_type));
      if (got.event_code !== want.ev.event_code)
        report_mismatch($sformatf("code %h, want %h", got.event_code, want.ev.event_code));
      if (got.event_value !== want.ev.event_value)
        report_mismatch($sformatf("value %h, want %h", got.event_value, want.ev.event_value));
      if (got.stamp_sec !== want.ev.stamp_sec)
        report_mismatch($sformatf("sec %h, want %h", got.stamp_sec, want.ev.stamp_sec));
      if (got.stamp_usec !== want.ev.stamp_usec)
        report_mismatch($sformatf("usec %h, want %h", got.stamp_usec, want.ev.stamp_usec));
      if (m_tlast !== want.last)
        report_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result();
  end

  // Receiver: ready in runs of random length, with stalls of random length in between while rx_stalls is set.
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      stall = rx_stalls ? gap_len() : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Watchdog: no item moved for %0d cycles", QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Status-only results, a held read served by a report, field extremes.
  task automatic test_status_and_pending();
    send_read(7'd0);
    send_read(7'd3);
    send_read(7'd0);
    send_read(7'd127);
    push_event(make_event(16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 20'd999999));
    push_event(make_event(SYNC_TYPE, 16'd1, 32'h8000_0000, 32'd0, 20'd0));
    push_event(make_event(16'd1, REPORT_CODE, 32'hFFFF_FFFF, 32'd1, 20'd1));
    push_event(make_event(16'h8000, 16'h8000, 32'd0, 32'h8000_0000, 20'h80000));
    push_event(report_event());
    send_read(7'd127);
    send_read(7'd1);
    push_event(make_event(SYNC_TYPE, REPORT_CODE, 32'h8000_0000, 32'hFFFF_FFFF, 20'd999999));
    repeat (3) push_event(rand_event());
    push_event(report_event());
    send_read(7'd1);
    send_read(7'd64);
    send_read(7'd2);
    push_event(rand_event());
    push_event(report_event());
    wait_drained();
  endtask

  // Packets of events closed by a sync report, with reads of varied counts in between.
  task automatic test_packet_reads();
    int i, n;
    for (i = 0; i < 30; i++) begin
      if (i % 10 == 0) begin
        tx_gaps = (i != 10);
        rx_stalls = (i != 20);
      end
      if (i == 15) wait_drained();
      if ($urandom_range(0, 9) < 6) begin
        n = $urandom_range(1, 6);
        repeat (n) push_event(rand_event());
        push_event(report_event());
      end else begin
        send_read($urandom_range(0, 4) == 0 ? CNT_W'(MAX_RUN) : CNT_W'($urandom_range(1, 12)));
      end
    end
    wait_drained();
  endtask

  // Bursts longer than the ring force overruns; the one report in a burst may
  // fall before the overrun, which leaves the commit point stale.
  task automatic test_ring_overflow();
    int burst, i, k, n;
    for (burst = 0; burst < 2; burst++) begin
      rx_stalls = (burst == 0);
      tx_gaps = (burst == 1);
      n = RING_DEPTH + $urandom_range(2, 12);
      k = $urandom_range(0, n - 1);
      for (i = 0; i < n; i++) push_event((i == k) ? report_event() : rand_event());
      send_read(7'd127);
      send_read(CNT_W'(MAX_RUN));
      send_read(CNT_W'($urandom_range(1, MAX_RUN)));
    end
    rx_stalls = 1'b1;
    tx_gaps = 1'b1;
    wait_drained();
  endtask

  // Unstructured mix: any request kind, any count, occasional reports.
  task automatic test_mixed_noise();
    int i, r;
    for (i = 0; i < 70; i++) begin
      if ($urandom_range(0, 1) == 1) begin
        r = $urandom_range(0, 3);
        if (r == 0) send_read(7'd0);
        else if (r == 1) send_read(CNT_W'($urandom_range(MAX_RUN + 1, 127)));
        else send_read(CNT_W'($urandom_range(1, MAX_RUN)));
      end else begin
        push_event($urandom_range(0, 3) == 0 ? report_event() : rand_event());
      end
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < RING_DEPTH; i++) ring_copy[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_status_and_pending();
    test_packet_reads();
    test_ring_overflow();
    test_mixed_noise();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d items and checked %0d results.", items_sent, results_seen);
    $display("Ring overruns seen: %0d; held reads served by a report: %0d.",
             overruns, held_served);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
